### hdl/ppcr_pkg.sv
// shared types, codes and table functions for the pointer power curve block
package ppcr_pkg;

    // input request codes (s_tuser)
    localparam logic [1:0] REQ_RATE   = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_BUTTON = 2'd2;

    // button event kinds
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_CLICK   = 2'd2;

    // result kinds (m_tuser)
    localparam logic [1:0] KIND_MOVE   = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    // key ids
    localparam logic [1:0] KEY_LEFT = 2'd0;

    // the only button that acts
    localparam logic [2:0] ACTIVE_BUTTON = 3'd3;

    // click counts
    localparam logic [2:0] COUNT_ONE   = 3'd1;
    localparam logic [2:0] COUNT_TWO   = 3'd2;
    localparam logic [2:0] COUNT_THREE = 3'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_MOVE_GAIN_X   = 3'd0;
    localparam logic [2:0] CFG_MOVE_EXP_X    = 3'd1;
    localparam logic [2:0] CFG_MOVE_GAIN_Y   = 3'd2;
    localparam logic [2:0] CFG_MOVE_EXP_Y    = 3'd3;
    localparam logic [2:0] CFG_SCROLL_GAIN_X = 3'd4;
    localparam logic [2:0] CFG_SCROLL_EXP_X  = 3'd5;
    localparam logic [2:0] CFG_SCROLL_GAIN_Y = 3'd6;
    localparam logic [2:0] CFG_SCROLL_EXP_Y  = 3'd7;

    localparam logic [15:0] GAIN_RESET = 16'd256;
    localparam logic [10:0] EXP_RESET  = 11'd256;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [1:0]         key;
        logic               down;
        logic               last;
    } result_t;

    function automatic longint unsigned isqrt64(input longint unsigned x);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v = x;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/2^b) in q1.16, entry 2^b is 1.0
    function automatic logic [16:0] log_entry(input int i, input int b);
        longint unsigned m;
        longint unsigned f;
        f = 0;
        if (i >= (1 << b)) return 17'd65536;
        m = longint'((1 << b) + i) << (30 - b);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                f = f | 64'd1;
            end
        end
        return 17'(f);
    endfunction

    // 2^(j/2^b) in q2.30, entry 2^b is 2.0
    function automatic logic [31:0] exp_entry(input int j, input int b);
        longint unsigned root [0:10];
        longint unsigned prod;
        prod = 64'd1 << 30;
        if (j >= (1 << b)) return 32'h8000_0000;
        root[0] = 64'd2 << 30;
        for (int n = 1; n <= 10; n++) begin
            root[n] = (n <= b) ? isqrt64(root[n - 1] << 30) : 64'd0;
        end
        for (int n = 0; n < 10; n++) begin
            if (n < b && ((j >> n) & 1) == 1) prod = (prod * root[b - n]) >> 30;
        end
        return 32'(prod);
    endfunction

endpackage

### hdl/ppcr_mul.sv
// shared signed multiplier with registered product
module ppcr_mul
(
    input  logic               clk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] prod
);

    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

### hdl/ppcr_curve.sv
// sequencer for the power curve of both axes over one shared multiplier
module ppcr_curve
#(
    parameter int LOG_TABLE_BITS = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic [15:0]        gain_x,
    input  logic [10:0]        exp_x,
    input  logic [15:0]        gain_y,
    input  logic [10:0]        exp_y,
    input  logic signed [15:0] rem_x,
    input  logic signed [15:0] rem_y,
    output logic               done,
    output logic signed [15:0] delta_x,
    output logic signed [15:0] delta_y,
    output logic signed [15:0] rem_x_out,
    output logic signed [15:0] rem_y_out
);

    localparam int B  = LOG_TABLE_BITS;
    localparam int N  = 1 << B;
    localparam int IW = B + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_LOGF  = 3'd2;
    localparam logic [2:0] ST_EXPI  = 3'd3;
    localparam logic [2:0] ST_EXPF  = 3'd4;
    localparam logic [2:0] ST_SHIFT = 3'd5;
    localparam logic [2:0] ST_ACC   = 3'd6;

    logic [16:0] log_tab [0:N];
    logic [31:0] exp_tab [0:N];

    for (genvar g = 0; g <= N; g++)
    begin : g_tab
        assign log_tab[g] = ppcr_pkg::log_entry(g, B);
        assign exp_tab[g] = ppcr_pkg::exp_entry(g, B);
    end

    logic [2:0]         state_reg, state_next;
    logic               axis_reg;
    logic [3:0]         p_reg;
    logic [16:0]        l0_reg;
    logic signed [7:0]  ti_reg;
    logic [31:0]        e0_reg;
    logic [62:0]        mag_reg;
    logic               done_reg;
    logic signed [15:0] dx_reg, dy_reg, rx_reg, ry_reg;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;

    ppcr_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // axis selection
    logic signed [15:0] v;
    logic [15:0]        gain;
    logic [10:0]        ex;
    logic signed [15:0] rem;
    logic               vneg;
    logic [15:0]        a;

    assign v    = axis_reg ? rate_y : rate_x;
    assign gain = axis_reg ? gain_y : gain_x;
    assign ex   = axis_reg ? exp_y : exp_x;
    assign rem  = axis_reg ? rem_y : rem_x;
    assign vneg = v[15];
    assign a    = vneg ? 16'(-v) : 16'(v);

    // normalize and split the mantissa
    logic [3:0]      p;
    logic [15:0]     a_norm;
    logic [14:0]     mant;
    logic [B-1:0]    idx_i;
    logic [14-B:0]   m_lo;
    logic [16:0]     l0, l1;

    always_comb
    begin
        p = 4'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (a[k]) p = 4'(k);
        end
    end

    assign a_norm = a << (4'd15 - p);
    assign mant   = a_norm[14:0];
    assign idx_i  = mant[14:15-B];
    assign m_lo   = mant[14-B:0];
    assign l0     = log_tab[{1'b0, idx_i}];
    assign l1     = log_tab[IW'(idx_i) + IW'(1)];

    // log value
    logic [16:0]        lf;
    logic [5:0]         p_m;
    logic signed [21:0] log_val;

    assign lf      = l0_reg + 17'(prod >> (15 - B));
    assign p_m     = 6'(p_reg) - 6'd12;
    assign log_val = signed'({p_m, 16'b0}) + signed'({5'b0, lf});

    // exponent split
    logic signed [23:0] t;
    logic signed [7:0]  ti;
    logic [15:0]        tf;
    logic [B-1:0]       idx_j;
    logic [15-B:0]      s;
    logic [31:0]        e0, e1;

    assign t     = prod[31:8];
    assign ti    = t[23:16];
    assign tf    = t[15:0];
    assign idx_j = tf[15:16-B];
    assign s     = tf[15-B:0];
    assign e0    = exp_tab[{1'b0, idx_j}];
    assign e1    = exp_tab[IW'(idx_j) + IW'(1)];

    logic [31:0] f;
    assign f = e0_reg + 32'(prod >> (16 - B));

    // scale to units of 2^-15
    logic signed [8:0] sh;
    logic [62:0]       prod_w;
    logic [62:0]       mag;
    logic signed [8:0] nsh;

    assign sh     = 9'sd23 - 9'(ti_reg);
    assign nsh    = -sh;
    assign prod_w = {15'b0, prod[47:0]};

    always_comb
    begin
        if (sh >= 9'sd64)
            mag = '0;
        else if (sh >= 9'sd0)
            mag = prod_w >> sh[5:0];
        else if (sh > -9'sd16)
            mag = prod_w << nsh[3:0];
        else
            mag = 63'(1) << 62;
    end

    // accumulate, split, saturate
    logic signed [64:0] sum;
    logic               sneg;
    logic [64:0]        sabs;
    logic [49:0]        qa;
    logic [14:0]        ra;
    logic signed [15:0] q_sat;
    logic signed [15:0] r_new;

    assign sum  = 65'(rem) + (vneg ? -signed'({2'b0, mag_reg}) : signed'({2'b0, mag_reg}));
    assign sneg = sum[64];
    assign sabs = sneg ? 65'(-sum) : 65'(sum);
    assign qa   = sabs[64:15];
    assign ra   = sabs[14:0];

    always_comb
    begin
        if (!sneg)
            q_sat = (qa > 50'd32767) ? 16'sh7fff : 16'(qa);
        else
            q_sat = (qa > 50'd32768) ? 16'sh8000 : 16'(-qa[15:0]);
        r_new = sneg ? 16'(-{1'b0, ra}) : 16'({1'b0, ra});
    end

    // multiplier operand selection
    always_comb
    begin
        case (state_reg)
            ST_PREP:
            begin
                op_a = 33'({1'b0, l1 - l0});
                op_b = 33'({1'b0, m_lo});
            end
            ST_LOGF:
            begin
                op_a = 33'({1'b0, ex});
                op_b = 33'(log_val);
            end
            ST_EXPI:
            begin
                op_a = 33'({1'b0, e1 - e0});
                op_b = 33'({1'b0, s});
            end
            ST_EXPF:
            begin
                op_a = 33'({1'b0, gain});
                op_b = 33'({1'b0, f});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:  state_next = start ? ST_PREP : ST_IDLE;
            ST_PREP:  state_next = (a == 16'd0) ? ST_ACC : ST_LOGF;
            ST_LOGF:  state_next = ST_EXPI;
            ST_EXPI:  state_next = ST_EXPF;
            ST_EXPF:  state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_ACC;
            ST_ACC:   state_next = axis_reg ? ST_IDLE : ST_PREP;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_ACC) && axis_reg;
            if (state_reg == ST_IDLE)
                axis_reg <= 1'b0;
            else if (state_reg == ST_ACC)
                axis_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_PREP:
            begin
                p_reg   <= p;
                l0_reg  <= l0;
                mag_reg <= '0;
            end
            ST_EXPI:
            begin
                ti_reg <= ti;
                e0_reg <= e0;
            end
            ST_SHIFT:
            begin
                mag_reg <= mag;
            end
            ST_ACC:
            begin
                if (axis_reg)
                begin
                    dy_reg <= q_sat;
                    ry_reg <= r_new;
                end
                else
                begin
                    dx_reg <= q_sat;
                    rx_reg <= r_new;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done      = done_reg;
    assign delta_x   = dx_reg;
    assign delta_y   = dy_reg;
    assign rem_x_out = rx_reg;
    assign rem_y_out = ry_reg;

endmodule

### hdl/pointer_power_curve_with_remainder.sv
// top level of the pointer power curve block with fractional carry
//
// input stream (s_*): one transaction is a rate sample, a timer tick or a
// button event, selected by s_tuser. a rate sample stores the x/y rates, a
// button-3 event may zero the rates, switch scroll mode or emit button
// changes, and a tick runs the power curve on both axes.
// output stream (m_*): one transaction per result; m_tuser gives the kind,
// m_tlast marks the last result of an input transaction.
// configuration: cfg_we/cfg_index/cfg_data write the eight gain and
// exponent registers; write only while the block is idle.
// sequencing: a button result goes into the hold on acceptance and then
// into the output register. a tick runs the curve unit on one shared
// multiplier through its PREP, LOGF, EXPI, EXPF, SHIFT and ACC states for
// each nonzero axis and PREP and ACC for a zero axis, then passes through
// the done register, the hold and the output register to m_tvalid.
// reset: rates, remainders and scroll mode clear, gains and exponents go to
// 1.0, nothing is pending.
// stall: results wait in a two-deep hold and the output register; s_tready
// stays low while the hold is not empty.
module pointer_power_curve_with_remainder
#(
    parameter int LOG_TABLE_BITS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // rate_x, rate_y, event_kind, click_count, button_id
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // delta_x, delta_y, key_id, key_down, zero pad
    output logic [1:0]  m_tuser,   // out_kind
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_CURVE = 1'b1;

    // input fields
    logic signed [15:0] in_rate_x, in_rate_y;
    logic [1:0]         in_event;
    logic [2:0]         in_count;
    logic [2:0]         in_button;

    assign in_rate_x = s_tdata[15:0];
    assign in_rate_y = s_tdata[31:16];
    assign in_event  = s_tdata[33:32];
    assign in_count  = s_tdata[36:34];
    assign in_button = s_tdata[39:37];

    // configuration registers
    logic [15:0] move_gain_x_reg, move_gain_y_reg, scroll_gain_x_reg, scroll_gain_y_reg;
    logic [10:0] move_exp_x_reg, move_exp_y_reg, scroll_exp_x_reg, scroll_exp_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_gain_x_reg   <= ppcr_pkg::GAIN_RESET;
            move_gain_y_reg   <= ppcr_pkg::GAIN_RESET;
            scroll_gain_x_reg <= ppcr_pkg::GAIN_RESET;
            scroll_gain_y_reg <= ppcr_pkg::GAIN_RESET;
            move_exp_x_reg    <= ppcr_pkg::EXP_RESET;
            move_exp_y_reg    <= ppcr_pkg::EXP_RESET;
            scroll_exp_x_reg  <= ppcr_pkg::EXP_RESET;
            scroll_exp_y_reg  <= ppcr_pkg::EXP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppcr_pkg::CFG_MOVE_GAIN_X:   move_gain_x_reg   <= cfg_data;
                ppcr_pkg::CFG_MOVE_EXP_X:    move_exp_x_reg    <= cfg_data[10:0];
                ppcr_pkg::CFG_MOVE_GAIN_Y:   move_gain_y_reg   <= cfg_data;
                ppcr_pkg::CFG_MOVE_EXP_Y:    move_exp_y_reg    <= cfg_data[10:0];
                ppcr_pkg::CFG_SCROLL_GAIN_X: scroll_gain_x_reg <= cfg_data;
                ppcr_pkg::CFG_SCROLL_EXP_X:  scroll_exp_x_reg  <= cfg_data[10:0];
                ppcr_pkg::CFG_SCROLL_GAIN_Y: scroll_gain_y_reg <= cfg_data;
                ppcr_pkg::CFG_SCROLL_EXP_Y:  scroll_exp_y_reg  <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    // block state
    logic                  state_reg;
    logic signed [15:0]    held_x_reg, held_y_reg;
    logic                  scroll_reg;
    logic signed [15:0]    rem_mx_reg, rem_my_reg, rem_sx_reg, rem_sy_reg;
    logic [1:0]            qcnt_reg;
    ppcr_pkg::result_t     q0_reg, q1_reg;
    logic                  m_tvalid_reg;
    ppcr_pkg::result_t     out_reg;

    logic accept;
    logic is_tick;
    logic is_btn;
    logic pop;

    assign s_tready = (state_reg == ST_IDLE) && (qcnt_reg == 2'd0);
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = s_tuser == ppcr_pkg::REQ_TICK;
    assign is_btn   = (s_tuser == ppcr_pkg::REQ_BUTTON) && (in_button == ppcr_pkg::ACTIVE_BUTTON);
    assign pop      = (qcnt_reg != 2'd0) && (!m_tvalid_reg || m_tready);

    // curve unit, driven with the active mode's settings
    logic               cv_done;
    logic signed [15:0] cv_dx, cv_dy, cv_rx, cv_ry;

    ppcr_curve
    #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    )
    u_curve
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && is_tick),
        .rate_x    (held_x_reg),
        .rate_y    (held_y_reg),
        .gain_x    (scroll_reg ? scroll_gain_x_reg : move_gain_x_reg),
        .exp_x     (scroll_reg ? scroll_exp_x_reg : move_exp_x_reg),
        .gain_y    (scroll_reg ? scroll_gain_y_reg : move_gain_y_reg),
        .exp_y     (scroll_reg ? scroll_exp_y_reg : move_exp_y_reg),
        .rem_x     (scroll_reg ? rem_sx_reg : rem_mx_reg),
        .rem_y     (scroll_reg ? rem_sy_reg : rem_my_reg),
        .done      (cv_done),
        .delta_x   (cv_dx),
        .delta_y   (cv_dy),
        .rem_x_out (cv_rx),
        .rem_y_out (cv_ry)
    );

    // button results
    ppcr_pkg::result_t btn_a, btn_b, tick_res;

    always_comb
    begin
        btn_a.kind = ppcr_pkg::KIND_BUTTON;
        btn_a.dx   = '0;
        btn_a.dy   = '0;
        btn_a.key  = ppcr_pkg::KEY_LEFT;
        btn_a.down = 1'b1;
        btn_a.last = 1'b1;
        btn_b      = btn_a;
        if (in_event == ppcr_pkg::EV_RELEASE)
            btn_a.down = 1'b0;
        if (in_event == ppcr_pkg::EV_CLICK)
        begin
            // click: key down without last, then key up with last
            btn_a.key  = 2'(in_count - 3'd1);
            btn_a.last = 1'b0;
            btn_b.key  = 2'(in_count - 3'd1);
            btn_b.down = 1'b0;
        end
        tick_res.kind = scroll_reg ? ppcr_pkg::KIND_SCROLL : ppcr_pkg::KIND_MOVE;
        tick_res.dx   = cv_dx;
        tick_res.dy   = cv_dy;
        tick_res.key  = ppcr_pkg::KEY_LEFT;
        tick_res.down = 1'b0;
        tick_res.last = 1'b1;
    end

    logic hold_one, hold_two;

    assign hold_one = accept && is_btn && (in_count == ppcr_pkg::COUNT_THREE)
                      && (in_event == ppcr_pkg::EV_PRESS || in_event == ppcr_pkg::EV_RELEASE);
    assign hold_two = accept && is_btn && (in_event == ppcr_pkg::EV_CLICK)
                      && (in_count >= ppcr_pkg::COUNT_ONE) && (in_count <= ppcr_pkg::COUNT_THREE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            scroll_reg   <= 1'b0;
            rem_mx_reg   <= '0;
            rem_my_reg   <= '0;
            rem_sx_reg   <= '0;
            rem_sy_reg   <= '0;
            qcnt_reg     <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept && s_tuser == ppcr_pkg::REQ_RATE)
            begin
                held_x_reg <= in_rate_x;
                held_y_reg <= in_rate_y;
            end
            if (accept && is_tick)
                state_reg <= ST_CURVE;
            if (accept && is_btn)
            begin
                if (in_event == ppcr_pkg::EV_RELEASE)
                begin
                    held_x_reg <= '0;
                    held_y_reg <= '0;
                end
                if (in_count == ppcr_pkg::COUNT_TWO && in_event == ppcr_pkg::EV_PRESS)
                    scroll_reg <= 1'b1;
                if (in_count == ppcr_pkg::COUNT_TWO && in_event == ppcr_pkg::EV_RELEASE)
                    scroll_reg <= 1'b0;
            end

            // hold pushes only land on an empty hold, so they never meet a pop
            if (cv_done)
            begin
                state_reg <= ST_IDLE;
                qcnt_reg  <= 2'd1;
                if (scroll_reg)
                begin
                    rem_sx_reg <= cv_rx;
                    rem_sy_reg <= cv_ry;
                end
                else
                begin
                    rem_mx_reg <= cv_rx;
                    rem_my_reg <= cv_ry;
                end
            end
            else if (hold_two)
                qcnt_reg <= 2'd2;
            else if (hold_one)
                qcnt_reg <= 2'd1;
            else if (pop)
                qcnt_reg <= qcnt_reg - 2'd1;

            if (pop)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // hold and output payload
    always_ff @(posedge clk)
    begin
        if (cv_done)
            q0_reg <= tick_res;
        else if (hold_one || hold_two)
        begin
            q0_reg <= btn_a;
            q1_reg <= btn_b;
        end
        else if (pop)
            q0_reg <= q1_reg;
        if (pop)
            out_reg <= q0_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_reg.down, out_reg.key, out_reg.dy, out_reg.dx};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

`ifndef SYNTH
    a_ready_needs_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (qcnt_reg == 2'd0))
        else $error("input ready while results are held");

    a_hold_depth: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg != 2'd3)
        else $error("result hold overflow");

    a_done_in_curve: assert property (@(posedge clk) disable iff (!rst_n)
        cv_done |-> (state_reg == ST_CURVE))
        else $error("curve finished outside a tick");

    a_tick_starts_curve: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick) |=> (state_reg == ST_CURVE))
        else $error("tick did not start the curve unit");

    a_click_fills_two: assert property (@(posedge clk) disable iff (!rst_n)
        hold_two |=> (qcnt_reg == 2'd2))
        else $error("click did not queue two results");
`endif

endmodule
